### sv/mwpc_pkg.sv
package mwpc_pkg;

  localparam int TimeoutW    = 16;
  localparam int PhaseCountW = 12;
  localparam int PhaseW      = 3;
  localparam int CfgIndexW   = 3;
  localparam int CfgDataW    = 16;

  localparam logic [TimeoutW-1:0]    TimeoutReset   = TimeoutW'(3600);
  localparam logic [PhaseCountW-1:0] FirstPwrReset  = PhaseCountW'(31);
  localparam logic [PhaseCountW-1:0] OffReset       = PhaseCountW'(62);
  localparam logic [PhaseCountW-1:0] BootWaitReset  = PhaseCountW'(62);
  localparam logic [PhaseCountW-1:0] PressReset     = PhaseCountW'(93);

  typedef enum logic [CfgIndexW-1:0] {
    REG_TIMEOUT   = 3'd0,
    REG_FIRST_PWR = 3'd1,
    REG_OFF       = 3'd2,
    REG_BOOT_WAIT = 3'd3,
    REG_PRESS     = 3'd4
  } reg_index_t;

  localparam logic [PhaseW-1:0] PH_FIRST_OFF   = 3'd0;
  localparam logic [PhaseW-1:0] PH_BOOT        = 3'd1;
  localparam logic [PhaseW-1:0] PH_PRESS       = 3'd2;
  localparam logic [PhaseW-1:0] PH_MONITOR     = 3'd3;
  localparam logic [PhaseW-1:0] PH_RESTART_OFF = 3'd4;

  typedef enum logic [4:0] {
    ST_FIRST_OFF   = 5'b00001,
    ST_BOOT        = 5'b00010,
    ST_PRESS       = 5'b00100,
    ST_MONITOR     = 5'b01000,
    ST_RESTART_OFF = 5'b10000
  } state_t;

  typedef struct packed {
    logic [TimeoutW-1:0]    timeout_ticks;
    logic [PhaseCountW-1:0] first_power_ticks;
    logic [PhaseCountW-1:0] off_ticks;
    logic [PhaseCountW-1:0] boot_wait_ticks;
    logic [PhaseCountW-1:0] press_ticks;
  } cfg_t;

  typedef struct packed {
    logic                power_on;
    logic                cmd_on;
    logic [PhaseW-1:0]   phase;
    logic [TimeoutW-1:0] timeout_left;
  } result_t;

endpackage

### sv/mwpc_if.sv
interface mwpc_in_if;
  logic valid;
  logic ready;
  logic resp_active;

  modport source(output valid, output resp_active, input ready);
  modport sink(input valid, input resp_active, output ready);
endinterface

interface mwpc_out_if;
  logic                              valid;
  logic                              ready;
  logic                              power_on;
  logic                              cmd_on;
  logic [mwpc_pkg::PhaseW-1:0]       phase;
  logic [mwpc_pkg::TimeoutW-1:0]     timeout_left;

  modport source(output valid, output power_on, output cmd_on, output phase,
                 output timeout_left, input ready);
  modport sink(input valid, input power_on, input cmd_on, input phase,
               input timeout_left, output ready);
endinterface

### sv/mwpc_cfg_regs.sv
module mwpc_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mwpc_pkg::CfgIndexW-1:0]    cfg_index,
  input  logic [mwpc_pkg::CfgDataW-1:0]     cfg_wdata,
  output mwpc_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks     <= mwpc_pkg::TimeoutReset;
      cfg.first_power_ticks <= mwpc_pkg::FirstPwrReset;
      cfg.off_ticks         <= mwpc_pkg::OffReset;
      cfg.boot_wait_ticks   <= mwpc_pkg::BootWaitReset;
      cfg.press_ticks       <= mwpc_pkg::PressReset;
    end else if (cfg_we) begin
      case (cfg_index)
        mwpc_pkg::REG_TIMEOUT: begin
          cfg.timeout_ticks <= cfg_wdata[mwpc_pkg::TimeoutW-1:0];
        end
        mwpc_pkg::REG_FIRST_PWR: begin
          cfg.first_power_ticks <= cfg_wdata[mwpc_pkg::PhaseCountW-1:0];
        end
        mwpc_pkg::REG_OFF: begin
          cfg.off_ticks <= cfg_wdata[mwpc_pkg::PhaseCountW-1:0];
        end
        mwpc_pkg::REG_BOOT_WAIT: begin
          cfg.boot_wait_ticks <= cfg_wdata[mwpc_pkg::PhaseCountW-1:0];
        end
        mwpc_pkg::REG_PRESS: begin
          cfg.press_ticks <= cfg_wdata[mwpc_pkg::PhaseCountW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### sv/mwpc_sequencer.sv
module mwpc_sequencer (
  input  logic               clk,
  input  logic               rst,
  input  logic               tick,
  input  logic               resp_active,
  input  mwpc_pkg::cfg_t     cfg,
  output mwpc_pkg::result_t  result
);

  mwpc_pkg::state_t                    state;
  mwpc_pkg::state_t                    state_next;
  logic [mwpc_pkg::PhaseCountW-1:0]    phase_count;
  logic [mwpc_pkg::PhaseCountW-1:0]    phase_count_next;
  logic [mwpc_pkg::TimeoutW-1:0]       timeout_count;
  logic [mwpc_pkg::TimeoutW-1:0]       timeout_count_next;
  logic [mwpc_pkg::TimeoutW-1:0]       timeout_dec;
  logic [mwpc_pkg::PhaseCountW-1:0]    duration;
  logic [mwpc_pkg::PhaseCountW-1:0]    count_inc;
  logic                                phase_done;

  always_comb begin
    case (state)
      mwpc_pkg::ST_FIRST_OFF:   duration = cfg.first_power_ticks;
      mwpc_pkg::ST_BOOT:        duration = cfg.boot_wait_ticks;
      mwpc_pkg::ST_PRESS:       duration = cfg.press_ticks;
      mwpc_pkg::ST_RESTART_OFF: duration = cfg.off_ticks;
      default:                  duration = '0;
    endcase
  end

  // A duration of zero behaves like one, since every stepped count is at least zero.
  assign count_inc  = phase_count + mwpc_pkg::PhaseCountW'(1);
  assign phase_done = (count_inc >= duration) || (count_inc == '0);

  always_comb begin
    if (resp_active) begin
      timeout_dec = cfg.timeout_ticks;
    end else if (timeout_count != '0) begin
      timeout_dec = timeout_count - mwpc_pkg::TimeoutW'(1);
    end else begin
      timeout_dec = timeout_count;
    end
  end

  always_comb begin
    state_next         = state;
    phase_count_next   = phase_count;
    timeout_count_next = timeout_count;
    case (state)
      mwpc_pkg::ST_FIRST_OFF, mwpc_pkg::ST_RESTART_OFF: begin
        phase_count_next = phase_done ? '0 : count_inc;
        if (phase_done) begin
          state_next = mwpc_pkg::ST_BOOT;
        end
      end
      mwpc_pkg::ST_BOOT: begin
        phase_count_next = phase_done ? '0 : count_inc;
        if (phase_done) begin
          state_next = mwpc_pkg::ST_PRESS;
        end
      end
      mwpc_pkg::ST_PRESS: begin
        phase_count_next = phase_done ? '0 : count_inc;
        if (phase_done) begin
          state_next         = mwpc_pkg::ST_MONITOR;
          timeout_count_next = cfg.timeout_ticks;
        end
      end
      mwpc_pkg::ST_MONITOR: begin
        timeout_count_next = timeout_dec;
        if (timeout_dec == '0) begin
          state_next       = mwpc_pkg::ST_RESTART_OFF;
          phase_count_next = '0;
        end
      end
      default: begin
        state_next       = mwpc_pkg::ST_FIRST_OFF;
        phase_count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= mwpc_pkg::ST_FIRST_OFF;
      phase_count   <= '0;
      timeout_count <= mwpc_pkg::TimeoutReset;
    end else if (tick) begin
      state         <= state_next;
      phase_count   <= phase_count_next;
      timeout_count <= timeout_count_next;
    end
  end

  always_comb begin
    result.timeout_left = timeout_count_next;
    result.power_on     = 1'b0;
    result.cmd_on       = 1'b0;
    case (state_next)
      mwpc_pkg::ST_FIRST_OFF: begin
        result.phase = mwpc_pkg::PH_FIRST_OFF;
      end
      mwpc_pkg::ST_BOOT: begin
        result.phase    = mwpc_pkg::PH_BOOT;
        result.power_on = 1'b1;
      end
      mwpc_pkg::ST_PRESS: begin
        result.phase    = mwpc_pkg::PH_PRESS;
        result.power_on = 1'b1;
        result.cmd_on   = 1'b1;
      end
      mwpc_pkg::ST_MONITOR: begin
        result.phase    = mwpc_pkg::PH_MONITOR;
        result.power_on = 1'b1;
      end
      mwpc_pkg::ST_RESTART_OFF: begin
        result.phase = mwpc_pkg::PH_RESTART_OFF;
      end
      default: begin
        result.phase = mwpc_pkg::PH_FIRST_OFF;
      end
    endcase
  end

endmodule

### sv/mwpc_out_buf.sv
module mwpc_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mwpc_pkg::result_t  push_data,
  output logic               full,
  input  logic               pop_ready,
  output logic               head_valid,
  output mwpc_pkg::result_t  head
);

  mwpc_pkg::result_t tail;
  logic              tail_valid;
  logic              pop;

  assign full = tail_valid;
  assign pop  = head_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      tail_valid <= 1'b0;
    end else if (pop) begin
      if (tail_valid) begin
        head_valid <= 1'b1;
        tail_valid <= push;
      end else begin
        head_valid <= push;
      end
    end else if (push) begin
      if (head_valid) begin
        tail_valid <= 1'b1;
      end else begin
        head_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (tail_valid) begin
        head <= tail;
        if (push) begin
          tail <= push_data;
        end
      end else if (push) begin
        head <= push_data;
      end
    end else if (push) begin
      if (head_valid) begin
        tail <= push_data;
      end else begin
        head <= push_data;
      end
    end
  end

endmodule

### sv/modem_watchdog_power_cycler_unit.sv
// Channel   Role     Payload                                     Request taken when
// in_ch     sink     resp_active                                 valid && ready
// out_ch    source   power_on, cmd_on, phase, timeout_left       valid && ready
// cfg       write    cfg_index, cfg_wdata                        cfg_we
//
// Each accepted request updates the phase sequencer, and its result is registered into the
// output buffer at the same edge; one request per cycle is sustained while out_ch is ready.
// A two-entry output buffer holds results, so input is stalled only when two results
// wait. Reset is synchronous and active high; it restores the register defaults and
// places the sequencer in the first power-off phase with the timeout at 3600 ticks.
module modem_watchdog_power_cycler_unit (
  input  logic                             clk,
  input  logic                             rst,
  mwpc_in_if.sink                          in_ch,
  mwpc_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [mwpc_pkg::CfgIndexW-1:0]   cfg_index,
  input  logic [mwpc_pkg::CfgDataW-1:0]    cfg_wdata
);

  mwpc_pkg::cfg_t    cfg;
  mwpc_pkg::result_t result;
  mwpc_pkg::result_t head;
  logic              full;
  logic              tick;

  assign in_ch.ready = !full;
  assign tick        = in_ch.valid && !full;

  mwpc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mwpc_sequencer u_sequencer (
    .clk         (clk),
    .rst         (rst),
    .tick        (tick),
    .resp_active (in_ch.resp_active),
    .cfg         (cfg),
    .result      (result)
  );

  mwpc_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (tick),
    .push_data  (result),
    .full       (full),
    .pop_ready  (out_ch.ready),
    .head_valid (out_ch.valid),
    .head       (head)
  );

  assign out_ch.power_on     = head.power_on;
  assign out_ch.cmd_on       = head.cmd_on;
  assign out_ch.phase        = head.phase;
  assign out_ch.timeout_left = head.timeout_left;

endmodule

### verif/tb_top.sv
module tb_top;
  import mwpc_pkg::*;

  typedef struct packed {
    logic    resp;
    logic    fixed;
    result_t want;
  } tick_row_t;

  localparam int DirectedRows = 25;
  localparam int RandomLegs   = 9;
  localparam int LegTicks     = 125;

  // Run with small durations so the rows walk through the restart sequence more than once.
  localparam tick_row_t DIRECTED_ROWS [DirectedRows] = '{
    '{1'b1, 1'b1, '{1'b1, 1'b0, PH_BOOT, 16'd3600}},
    '{1'b0, 1'b0, result_t'(0)},
    '{1'b1, 1'b1, '{1'b1, 1'b0, PH_MONITOR, 16'd2}},
    '{1'b0, 1'b0, result_t'(0)},
    '{1'b1, 1'b0, result_t'(0)},
    '{1'b0, 1'b0, result_t'(0)},
    '{1'b0, 1'b1, '{1'b0, 1'b0, PH_RESTART_OFF, 16'd0}},
    '{1'b1, 1'b0, result_t'(0)},
    '{1'b0, 1'b0, result_t'(0)},
    '{1'b1, 1'b0, result_t'(0)},
    '{1'b0, 1'b0, result_t'(0)},
    '{1'b1, 1'b0, result_t'(0)},
    '{1'b1, 1'b0, result_t'(0)},
    '{1'b0, 1'b0, result_t'(0)},
    '{1'b1, 1'b0, result_t'(0)},
    '{1'b0, 1'b0, result_t'(0)},
    '{1'b0, 1'b0, result_t'(0)},
    '{1'b1, 1'b0, result_t'(0)},
    '{1'b1, 1'b0, result_t'(0)},
    '{1'b0, 1'b0, result_t'(0)},
    '{1'b1, 1'b0, result_t'(0)},
    '{1'b1, 1'b0, result_t'(0)},
    '{1'b0, 1'b0, result_t'(0)},
    '{1'b0, 1'b0, result_t'(0)},
    '{1'b0, 1'b0, result_t'(0)}
  };

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_wdata;

  mwpc_in_if  in_ch();
  mwpc_out_if out_ch();

  modem_watchdog_power_cycler_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  cfg_t                   shadow_cfg;
  logic [PhaseW-1:0]      seq_phase;
  logic [PhaseCountW-1:0] seq_count;
  logic [TimeoutW-1:0]    seq_timeout;
  result_t                pending_results[$];
  int                     error_count = 0;
  bit                     tx_burst = 1'b0;
  bit                     rx_burst = 1'b0;
  int                     active_pct = 50;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // A zero duration ends the phase after one tick, the same as a duration of one.
  function automatic bit phase_elapsed(input logic [PhaseCountW-1:0] duration);
    seq_count = seq_count + 1'b1;
    if (seq_count >= duration || seq_count == '0) begin
      seq_count = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic result_t advance_sequencer(input logic resp);
    result_t r;
    case (seq_phase)
      PH_FIRST_OFF: begin
        if (phase_elapsed(shadow_cfg.first_power_ticks)) seq_phase = PH_BOOT;
      end
      PH_RESTART_OFF: begin
        if (phase_elapsed(shadow_cfg.off_ticks)) seq_phase = PH_BOOT;
      end
      PH_BOOT: begin
        if (phase_elapsed(shadow_cfg.boot_wait_ticks)) seq_phase = PH_PRESS;
      end
      PH_PRESS: begin
        if (phase_elapsed(shadow_cfg.press_ticks)) begin
          seq_phase   = PH_MONITOR;
          seq_timeout = shadow_cfg.timeout_ticks;
        end
      end
      PH_MONITOR: begin
        if (resp) begin
          seq_timeout = shadow_cfg.timeout_ticks;
        end else if (seq_timeout != '0) begin
          seq_timeout = seq_timeout - 1'b1;
        end
        if (seq_timeout == '0) begin
          seq_phase = PH_RESTART_OFF;
          seq_count = '0;
        end
      end
      default: begin
        seq_phase = PH_FIRST_OFF;
        seq_count = '0;
      end
    endcase
    r.power_on     = (seq_phase == PH_BOOT || seq_phase == PH_PRESS ||
                      seq_phase == PH_MONITOR);
    r.cmd_on       = (seq_phase == PH_PRESS);
    r.phase        = seq_phase;
    r.timeout_left = seq_timeout;
    return r;
  endfunction

  function automatic logic [CfgDataW-1:0] pick_duration();
    int               r;
    logic [PhaseCountW-1:0] d;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      d = PhaseCountW'($urandom_range(0, 3));
    end else if (r < 9) begin
      d = PhaseCountW'($urandom_range(4, 15));
    end else begin
      d = PhaseCountW'($urandom_range(16, 60));
    end
    return {4'($urandom), d};
  endfunction

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_TIMEOUT:   shadow_cfg.timeout_ticks     = data[TimeoutW-1:0];
      REG_FIRST_PWR: shadow_cfg.first_power_ticks = data[PhaseCountW-1:0];
      REG_OFF:       shadow_cfg.off_ticks         = data[PhaseCountW-1:0];
      REG_BOOT_WAIT: shadow_cfg.boot_wait_ticks   = data[PhaseCountW-1:0];
      REG_PRESS:     shadow_cfg.press_ticks       = data[PhaseCountW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input logic [CfgDataW-1:0] tmo, input logic [CfgDataW-1:0] first,
                           input logic [CfgDataW-1:0] off, input logic [CfgDataW-1:0] boot,
                           input logic [CfgDataW-1:0] press);
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_FIRST_PWR, first);
    write_reg(REG_OFF, off);
    write_reg(REG_BOOT_WAIT, boot);
    write_reg(REG_PRESS, press);
    write_reg(CfgIndexW'($urandom_range(5, 7)), CfgDataW'($urandom));
  endtask

  task automatic send_tick(input logic resp, input logic fixed, input result_t want);
    int      gap;
    result_t predicted;
    gap = tx_burst ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.resp_active <= resp;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predicted = advance_sequencer(resp);
    pending_results.push_back(fixed ? want : predicted);
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  initial begin
    int               leg;
    int               n;
    logic [CfgDataW-1:0] tmo;
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.resp_active = 1'b0;
    shadow_cfg.timeout_ticks     = TimeoutReset;
    shadow_cfg.first_power_ticks = FirstPwrReset;
    shadow_cfg.off_ticks         = OffReset;
    shadow_cfg.boot_wait_ticks   = BootWaitReset;
    shadow_cfg.press_ticks       = PressReset;
    seq_phase   = PH_FIRST_OFF;
    seq_count   = '0;
    seq_timeout = TimeoutReset;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_all(16'd2, 16'd0, 16'd2, 16'd1, 16'd0);
    for (n = 0; n < DirectedRows; n++) begin
      send_tick(DIRECTED_ROWS[n].resp, DIRECTED_ROWS[n].fixed, DIRECTED_ROWS[n].want);
    end
    settle();

    for (leg = 0; leg < RandomLegs; leg++) begin
      tx_burst   = (leg % 3 == 0);
      rx_burst   = (leg % 4 == 1);
      active_pct = $urandom_range(0, 60);
      case (leg)
        1: write_all(16'd0, pick_duration(), pick_duration(), pick_duration(),
                     pick_duration());
        2: write_all(16'd1, 16'd0, 16'd0, 16'd0, 16'd0);
        3: write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: begin
          tmo = ($urandom_range(0, 9) == 0) ? CfgDataW'($urandom_range(13, 2000))
                                             : CfgDataW'($urandom_range(1, 12));
          write_all(tmo, pick_duration(), pick_duration(), pick_duration(),
                    pick_duration());
        end
      endcase
      for (n = 0; n < LegTicks; n++) begin
        send_tick($urandom_range(0, 99) < active_pct, 1'b0, result_t'(0));
      end
      settle();
    end

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    int      gap;
    result_t got;
    result_t want;
    out_ch.ready = 1'b0;
    forever begin
      gap = rx_burst ? 0 : $urandom_range(0, 5);
      @(negedge clk);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid === 1'b1 && rst === 1'b0));
      got.power_on     = out_ch.power_on;
      got.cmd_on       = out_ch.cmd_on;
      got.phase        = out_ch.phase;
      got.timeout_left = out_ch.timeout_left;
      if (pending_results.size() == 0) begin
        $error("Result arrived with no request outstanding.");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.power_on !== want.power_on) begin
          $error("power_on: expected %0d, got %0d", want.power_on, got.power_on);
          error_count++;
        end
        if (got.cmd_on !== want.cmd_on) begin
          $error("cmd_on: expected %0d, got %0d", want.cmd_on, got.cmd_on);
          error_count++;
        end
        if (got.phase !== want.phase) begin
          $error("phase: expected %0d, got %0d", want.phase, got.phase);
          error_count++;
        end
        if (got.timeout_left !== want.timeout_left) begin
          $error("timeout_left: expected %0d, got %0d", want.timeout_left,
                 got.timeout_left);
          error_count++;
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### filelist.f
sv/mwpc_pkg.sv
sv/mwpc_if.sv
sv/mwpc_cfg_regs.sv
sv/mwpc_sequencer.sv
sv/mwpc_out_buf.sv
sv/modem_watchdog_power_cycler_unit.sv
verif/tb_top.sv
